[rtl/pcrd_pkg.sv]
// ----------------------------------------------------------------------------
// pcrd_pkg
// Shared types, codes and helpers for the capture-record deframer.
// ----------------------------------------------------------------------------
package pcrd_pkg;

	// result kinds
	localparam logic [2:0] KIND_DATA      = 3'd0;
	localparam logic [2:0] KIND_FRAME_END = 3'd1;
	localparam logic [2:0] KIND_BAD_ID    = 3'd2;
	localparam logic [2:0] KIND_TOO_LONG  = 3'd3;
	localparam logic [2:0] KIND_TRUNC     = 3'd4;

	// octet stuffing
	localparam logic [7:0] FLAG_BYTE = 8'h7e;
	localparam logic [7:0] ESC_BYTE  = 8'h7d;
	localparam logic [7:0] ESC_XOR   = 8'h20;

	// one result transaction
	typedef struct packed {
		logic [2:0]  kind;
		logic        dir;
		logic [7:0]  data;
		logic [13:0] len;
		logic [63:0] secs;
		logic [3:0]  tenths;
	} res_t;

	// x / 10 by reciprocal multiply, exact for any x below 2560 (quotient fits 8 bits)
	function automatic logic [7:0] div10(input logic [11:0] x);
		logic [27:0] p;
		p = {16'd0, x} * 28'd52429;
		return p[26:19];
	endfunction

endpackage

[rtl/ppp_capture_record_deframer.sv]
// ----------------------------------------------------------------------------
// ppp_capture_record_deframer
// Parses a capture-log byte stream and deframes octet-stuffed data per side.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one log byte per transaction, or an
// end_of_stream marker. Output channel (out_valid/out_ready): at most one
// result per input byte: a deframed data byte, a frame end with its length
// and the current clock, or an error (bad record id, frame too long,
// truncated record). After an error or end of stream the block halts and
// swallows every later input until reset.
// Throughput: one input byte per cycle while the skid register is empty. The output register plus a one-deep
// skid register keep input flowing while a result waits; in_ready drops
// only while the skid register is occupied.
// Clock steps are divided by ten one log byte at a time as the step value
// arrives; the seconds add is applied in the cycle after the step record.
// Reset (arst_n low) clears the parser, the clock, both frame counters and
// escape flags, and empties the output side.
// ----------------------------------------------------------------------------
module ppp_capture_record_deframer #(
	parameter int MAX_FRAME = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        end_of_stream,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  result_kind,
	output logic        direction,
	output logic [7:0]  out_byte,
	output logic [13:0] frame_length,
	output logic [63:0] time_seconds,
	output logic [3:0]  time_tenths
);
	import pcrd_pkg::*;

	// largest frame, in bytes
	localparam logic [13:0] FRAME_LIMIT = 14'(MAX_FRAME);

	// parser phases
	localparam logic [2:0] PH_ID     = 3'd0;
	localparam logic [2:0] PH_LEN_HI = 3'd1;
	localparam logic [2:0] PH_LEN_LO = 3'd2;
	localparam logic [2:0] PH_DATA   = 3'd3;
	localparam logic [2:0] PH_RESET  = 3'd4;
	localparam logic [2:0] PH_LSTEP  = 3'd5;
	localparam logic [2:0] PH_SSTEP  = 3'd6;

	// record ids
	localparam logic [7:0] ID_SENT   = 8'h01;
	localparam logic [7:0] ID_RECV   = 8'h02;
	localparam logic [7:0] ID_SDELIM = 8'h03;
	localparam logic [7:0] ID_RDELIM = 8'h04;
	localparam logic [7:0] ID_LSTEP  = 8'h05;
	localparam logic [7:0] ID_SSTEP  = 8'h06;
	localparam logic [7:0] ID_RESET  = 8'h07;

	// parser state
	logic [2:0]  phase_q, phase_d;
	logic [15:0] bytes_left_q, bytes_left_d;
	logic        side_q, side_d;
	logic [7:0]  len_hi_q, len_hi_d;
	logic [31:0] step_q, step_d;
	logic [28:0] quo_q, quo_d;
	logic [3:0]  rem_q, rem_d;
	logic [63:0] secs_q, secs_d;
	logic [3:0]  tenths_q, tenths_d;
	logic [1:0]  esc_q, esc_d;
	logic [13:0] cnt_q [2];
	logic [13:0] cnt_d [2];
	logic        halted_q, halted_d;
	logic        pend_v_q, pend_v_d;
	logic [28:0] pend_q, pend_d;
	logic        pend_c_q, pend_c_d;

	// output side
	logic        res_v;
	res_t        res;
	logic        res_v_q, skid_v_q;
	res_t        res_q, skid_q;

	logic        in_fire, out_fire;
	logic [15:0] bl_dec;

	// long step: one base-256 digit of long division per byte
	logic [11:0] lx;
	logic [7:0]  lq;
	logic [11:0] lr_full;
	logic [3:0]  lr;
	logic [28:0] lquo;
	logic [4:0]  lt;
	logic        lcarry;
	logic [4:0]  lt_adj;

	// short step: tenths plus one byte
	logic [11:0] sx;
	logic [7:0]  sq;
	logic [11:0] sr_full;

	// deframe helpers
	logic [13:0] cnt_s;
	logic        esc_s;
	logic [7:0]  byte_x;

	assign in_ready = !skid_v_q;
	assign in_fire  = in_valid && in_ready;
	assign out_fire = res_v_q && out_ready;
	assign bl_dec   = bytes_left_q - 16'd1;

	assign lx      = {rem_q, in_byte};
	assign lq      = div10(lx);
	assign lr_full = lx - 12'(lq) * 12'd10;
	assign lr      = lr_full[3:0];
	assign lquo    = {quo_q[20:0], lq};
	assign lt      = {1'b0, lr} + {1'b0, tenths_q};
	assign lcarry  = (lt >= 5'd10);
	assign lt_adj  = lcarry ? (lt - 5'd10) : lt;

	assign sx      = {8'd0, tenths_q} + {4'd0, in_byte};
	assign sq      = div10(sx);
	assign sr_full = sx - 12'(sq) * 12'd10;

	assign cnt_s  = cnt_q[side_q];
	assign esc_s  = esc_q[side_q];
	assign byte_x = esc_s ? (in_byte ^ ESC_XOR) : in_byte;

	// next state and result
	always_comb begin
		phase_d      = phase_q;
		bytes_left_d = bytes_left_q;
		side_d       = side_q;
		len_hi_d     = len_hi_q;
		step_d       = step_q;
		quo_d        = quo_q;
		rem_d        = rem_q;
		secs_d       = secs_q;
		tenths_d     = tenths_q;
		esc_d        = esc_q;
		cnt_d        = cnt_q;
		halted_d     = halted_q;
		pend_v_d     = 1'b0;
		pend_d       = pend_q;
		pend_c_d     = pend_c_q;
		res_v        = 1'b0;
		res          = '0;

		// deferred seconds add from a clock step
		if (pend_v_q) begin
			secs_d = secs_q + {35'd0, pend_q} + {63'd0, pend_c_q};
		end

		if (in_fire && !halted_q) begin
			if (end_of_stream) begin
				halted_d = 1'b1;
				if (phase_q != PH_ID) begin
					res_v    = 1'b1;
					res.kind = KIND_TRUNC;
				end
			end else begin
				unique case (phase_q)
					PH_ID: begin
						unique case (in_byte) inside
							ID_SENT, ID_RECV: begin
								side_d  = (in_byte == ID_RECV);
								phase_d = PH_LEN_HI;
							end
							ID_SDELIM, ID_RDELIM: begin
							end
							ID_LSTEP: begin
								quo_d        = '0;
								rem_d        = '0;
								bytes_left_d = 16'd4;
								phase_d      = PH_LSTEP;
							end
							ID_SSTEP: begin
								phase_d = PH_SSTEP;
							end
							ID_RESET: begin
								step_d       = '0;
								bytes_left_d = 16'd4;
								phase_d      = PH_RESET;
							end
							default: begin
								halted_d = 1'b1;
								res_v    = 1'b1;
								res.kind = KIND_BAD_ID;
								res.data = in_byte;
							end
						endcase
					end
					PH_LEN_HI: begin
						len_hi_d = in_byte;
						phase_d  = PH_LEN_LO;
					end
					PH_LEN_LO: begin
						bytes_left_d = {len_hi_q, in_byte};
						phase_d      = ({len_hi_q, in_byte} == 16'd0) ? PH_ID : PH_DATA;
					end
					PH_DATA: begin
						bytes_left_d = bl_dec;
						if (bl_dec == 16'd0) begin
							phase_d = PH_ID;
						end
						// per-side deframing
						if (in_byte == FLAG_BYTE) begin
							if (cnt_s != 14'd0) begin
								esc_d[side_q] = 1'b0;
								cnt_d[side_q] = '0;
								res_v         = 1'b1;
								res.kind      = KIND_FRAME_END;
								res.dir       = side_q;
								res.len       = cnt_s;
								res.secs      = secs_q;
								res.tenths    = tenths_q;
							end
						end else if (in_byte == ESC_BYTE && !esc_s) begin
							esc_d[side_q] = 1'b1;
						end else begin
							esc_d[side_q] = 1'b0;
							res_v         = 1'b1;
							res.dir       = side_q;
							res.data      = byte_x;
							if (cnt_s >= FRAME_LIMIT) begin
								halted_d = 1'b1;
								res.kind = KIND_TOO_LONG;
							end else begin
								cnt_d[side_q] = cnt_s + 14'd1;
								res.kind      = KIND_DATA;
							end
						end
					end
					PH_RESET, PH_LSTEP: begin
						step_d       = {step_q[23:0], in_byte};
						quo_d        = lquo;
						rem_d        = lr;
						bytes_left_d = bl_dec;
						if (bl_dec == 16'd0) begin
							phase_d = PH_ID;
							if (phase_q == PH_RESET) begin
								secs_d   = {32'd0, step_q[23:0], in_byte};
								tenths_d = '0;
							end else begin
								tenths_d = lt_adj[3:0];
								pend_v_d = 1'b1;
								pend_d   = lquo;
								pend_c_d = lcarry;
							end
						end
					end
					PH_SSTEP: begin
						tenths_d = sr_full[3:0];
						pend_v_d = 1'b1;
						pend_d   = {21'd0, sq};
						pend_c_d = 1'b0;
						phase_d  = PH_ID;
					end
					default: begin
						phase_d = PH_ID;
					end
				endcase
			end
		end
	end

	// parser registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_ID;
			bytes_left_q <= '0;
			side_q       <= 1'b0;
			len_hi_q     <= '0;
			step_q       <= '0;
			quo_q        <= '0;
			rem_q        <= '0;
			secs_q       <= '0;
			tenths_q     <= '0;
			esc_q        <= '0;
			cnt_q[0]     <= '0;
			cnt_q[1]     <= '0;
			halted_q     <= 1'b0;
			pend_v_q     <= 1'b0;
			pend_q       <= '0;
			pend_c_q     <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			bytes_left_q <= bytes_left_d;
			side_q       <= side_d;
			len_hi_q     <= len_hi_d;
			step_q       <= step_d;
			quo_q        <= quo_d;
			rem_q        <= rem_d;
			secs_q       <= secs_d;
			tenths_q     <= tenths_d;
			esc_q        <= esc_d;
			cnt_q[0]     <= cnt_d[0];
			cnt_q[1]     <= cnt_d[1];
			halted_q     <= halted_d;
			pend_v_q     <= pend_v_d;
			pend_q       <= pend_d;
			pend_c_q     <= pend_c_d;
		end
	end

	// output and skid valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_fire) begin
				skid_v_q <= 1'b0;
			end
		end else if (res_v) begin
			if (!res_v_q || out_fire) begin
				res_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (out_fire) begin
			res_v_q <= 1'b0;
		end
	end

	// output and skid payload
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_fire) begin
				res_q <= skid_q;
			end
		end else if (res_v) begin
			if (!res_v_q || out_fire) begin
				res_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign out_valid    = res_v_q;
	assign result_kind  = res_q.kind;
	assign direction    = res_q.dir;
	assign out_byte     = res_q.data;
	assign frame_length = res_q.len;
	assign time_seconds = res_q.secs;
	assign time_tenths  = res_q.tenths;

endmodule

[rtl/pcrd_checker.sv]
// ----------------------------------------------------------------------------
// pcrd_checker
// Port-level checks on the result channel of the capture-record deframer.
// ----------------------------------------------------------------------------
module pcrd_checker #(
	parameter int MAX_FRAME = 8192
) (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  result_kind,
	input logic        direction,
	input logic [7:0]  out_byte,
	input logic [13:0] frame_length,
	input logic [63:0] time_seconds,
	input logic [3:0]  time_tenths
);
	import pcrd_pkg::*;

	localparam logic [13:0] FRAME_LIMIT = 14'(MAX_FRAME);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind)
			&& $stable(out_byte) && $stable(frame_length) && $stable(direction))
		else $error("stalled result changed");

	// only defined kinds
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> result_kind == KIND_DATA || result_kind == KIND_FRAME_END
			|| result_kind == KIND_BAD_ID || result_kind == KIND_TOO_LONG
			|| result_kind == KIND_TRUNC)
		else $error("undefined result kind");

	// frame end carries a nonzero length within the limit, a sane tenths value and no data byte
	a_fend: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_FRAME_END |->
			frame_length != 14'd0 && frame_length <= FRAME_LIMIT && time_tenths < 4'd10
			&& out_byte == 8'd0)
		else $error("bad frame end transaction");

	// length and clock only on frame ends
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != KIND_FRAME_END |->
			frame_length == 14'd0 && time_seconds == 64'd0 && time_tenths == 4'd0)
		else $error("length or clock on non frame end");

	// stream-level errors have no side
	a_dir: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == KIND_BAD_ID || result_kind == KIND_TRUNC)
			|-> !direction)
		else $error("side set on stream error");

endmodule

bind ppp_capture_record_deframer pcrd_checker #(.MAX_FRAME(MAX_FRAME)) u_pcrd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.result_kind  (result_kind),
	.direction    (direction),
	.out_byte     (out_byte),
	.frame_length (frame_length),
	.time_seconds (time_seconds),
	.time_tenths  (time_tenths)
);
